### src/nac_pkg.sv
`timescale 1ns / 1ps
package nac_pkg;

  localparam logic [1:0] REQ_ADD      = 2'd0;
  localparam logic [1:0] REQ_REMOVE   = 2'd1;
  localparam logic [1:0] REQ_CLASSIFY = 2'd2;

  localparam logic [1:0] FAM_MAC = 2'd0;
  localparam logic [1:0] FAM_IP4 = 2'd1;
  localparam logic [1:0] FAM_IP6 = 2'd2;

  localparam logic [2:0] CLS_ERROR     = 3'd0;
  localparam logic [2:0] CLS_NONE      = 3'd1;
  localparam logic [2:0] CLS_OTHER     = 3'd2;
  localparam logic [2:0] CLS_LOCAL     = 3'd3;
  localparam logic [2:0] CLS_LOCALNET  = 3'd4;
  localparam logic [2:0] CLS_RESERVED  = 3'd5;
  localparam logic [2:0] CLS_MULTICAST = 3'd6;
  localparam logic [2:0] CLS_BROADCAST = 3'd7;

  localparam int unsigned BuiltinEntries = 11;

  typedef enum logic [1:0] {
    KIND_DONE,
    KIND_ADD,
    KIND_REMOVE,
    KIND_CLASSIFY
  } kind_e;

  typedef struct packed {
    logic       valid;
    logic [1:0] fam;
    logic [2:0] slot;
    logic [2:0] cls;
    logic [7:0] plen;
  } info_t;

  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
    info_t       info;
  } entry_t;

  typedef struct packed {
    kind_e        kind;
    logic [1:0]   fam;
    logic [127:0] key;
    logic [7:0]   plen;
    logic [2:0]   slot;
    logic [2:0]   cls;
    logic         host;
    logic         res_ok;
    logic [2:0]   res_class;
  } item_t;

  function automatic logic [127:0] nac_mask(logic [1:0] fam, logic [7:0] p);
    logic [127:0] m;
    m = '0;
    if (p != 8'd0) begin
      case (fam)
        FAM_MAC: m[47:0] = '1;
        FAM_IP4: m[31:0] = ~(32'hffff_ffff >> p);
        FAM_IP6: m = ~({128{1'b1}} >> p);
        default: m = '0;
      endcase
    end
    return m;
  endfunction

  function automatic info_t nac_info(logic [1:0] fam, logic [2:0] cls, logic [7:0] p);
    info_t i;
    i.valid = 1'b1;
    i.fam   = fam;
    i.slot  = 3'd0;
    i.cls   = cls;
    i.plen  = p;
    return i;
  endfunction

  function automatic entry_t nac_builtin(logic [3:0] idx);
    entry_t e;
    e = '0;
    case (idx)
      4'd0: begin
        e.key_low = 64'h7F00_0000; e.info = nac_info(FAM_IP4, CLS_RESERVED, 8'd8);
      end
      4'd1: begin
        e.key_low = 64'h0A00_0000; e.info = nac_info(FAM_IP4, CLS_RESERVED, 8'd8);
      end
      4'd2: begin
        e.key_low = 64'h6440_0000; e.info = nac_info(FAM_IP4, CLS_RESERVED, 8'd10);
      end
      4'd3: begin
        e.key_low = 64'hAC10_0000; e.info = nac_info(FAM_IP4, CLS_RESERVED, 8'd12);
      end
      4'd4: begin
        e.key_low = 64'hC0A8_0000; e.info = nac_info(FAM_IP4, CLS_RESERVED, 8'd16);
      end
      4'd5: begin
        e.key_high = 64'hFC00_0000_0000_0000;
        e.info = nac_info(FAM_IP6, CLS_RESERVED, 8'd7);
      end
      4'd6: begin
        e.key_high = 64'hFD00_0000_0000_0000;
        e.info = nac_info(FAM_IP6, CLS_RESERVED, 8'd8);
      end
      4'd7: begin
        e.key_high = 64'hFE80_0000_0000_0000;
        e.info = nac_info(FAM_IP6, CLS_RESERVED, 8'd10);
      end
      4'd8: begin
        e.key_low = 64'hE000_0000; e.info = nac_info(FAM_IP4, CLS_MULTICAST, 8'd4);
      end
      4'd9: begin
        e.key_high = 64'hFF00_0000_0000_0000;
        e.info = nac_info(FAM_IP6, CLS_MULTICAST, 8'd8);
      end
      4'd10: begin
        e.key_low = 64'hA9FE_FFFF; e.info = nac_info(FAM_IP4, CLS_BROADCAST, 8'd32);
      end
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

### src/nac_front.sv
`timescale 1ns / 1ps
module nac_front #(
  parameter int IFACE_SLOTS = 7
) (
  input  logic [1:0]           req_type_i,
  input  logic [1:0]           family_i,
  input  logic [63:0]          addr_high_i,
  input  logic [63:0]          addr_low_i,
  input  logic [7:0]           prefix_len_i,
  input  logic [2:0]           iface_slot_i,
  input  logic [2:0]           entry_type_i,
  output nac_pkg::item_t       item_o
);
  import nac_pkg::*;

  logic [7:0]   full_bits;
  logic [7:0]   p;
  logic         bad;
  logic [127:0] addr;
  logic [127:0] key;
  logic [127:0] query;
  logic [2:0]   slot;
  logic [2:0]   cls;

  always_comb begin
    case (family_i)
      FAM_MAC: full_bits = 8'd48;
      FAM_IP4: full_bits = 8'd32;
      default: full_bits = 8'd128;
    endcase
    bad = (family_i == FAM_IP4 && prefix_len_i > 8'd32) ||
          (family_i == FAM_IP6 && prefix_len_i > 8'd128) ||
          (family_i != FAM_MAC && family_i != FAM_IP4 && family_i != FAM_IP6);
    if (family_i == FAM_MAC || prefix_len_i == 8'd0) begin
      p = full_bits;
    end else begin
      p = prefix_len_i;
    end
    addr  = {addr_high_i, addr_low_i};
    key   = addr & nac_mask(family_i, p);
    query = addr & nac_mask(family_i, full_bits);
    slot  = (family_i == FAM_MAC) ? 3'd0 : iface_slot_i;
    cls   = entry_type_i;
    if (family_i != FAM_MAC && cls == CLS_LOCAL && p != full_bits) begin
      cls = CLS_LOCALNET;
    end

    item_o           = '0;
    item_o.kind      = KIND_DONE;
    item_o.fam       = family_i;
    item_o.plen      = p;
    item_o.slot      = slot;
    item_o.cls       = cls;
    item_o.key       = key;
    item_o.host      = (family_i != FAM_MAC) && (p == full_bits);
    item_o.res_ok    = 1'b0;
    item_o.res_class = CLS_ERROR;

    case (req_type_i)
      REQ_CLASSIFY: begin
        item_o.res_ok = 1'b1;
        item_o.key    = query;
        if (bad) begin
          item_o.res_class = CLS_ERROR;
        end else if (family_i == FAM_MAC) begin
          if (query[40]) begin
            item_o.res_class = CLS_MULTICAST;
          end else if (query[47:0] == '1) begin
            item_o.res_class = CLS_BROADCAST;
          end else if (query[47:0] == '0) begin
            item_o.res_class = CLS_NONE;
          end else begin
            item_o.kind = KIND_CLASSIFY;
          end
        end else if (family_i == FAM_IP4) begin
          if (query[31:0] == '0) begin
            item_o.res_class = CLS_NONE;
          end else if (query[31:0] == '1) begin
            item_o.res_class = CLS_BROADCAST;
          end else begin
            item_o.kind = KIND_CLASSIFY;
          end
        end else begin
          if (query == '0) begin
            item_o.res_class = CLS_NONE;
          end else begin
            item_o.kind = KIND_CLASSIFY;
          end
        end
      end
      REQ_ADD, REQ_REMOVE: begin
        if (!bad && int'(slot) <= IFACE_SLOTS) begin
          item_o.kind = (req_type_i == REQ_ADD) ? KIND_ADD : KIND_REMOVE;
        end
      end
      default: item_o.kind = KIND_DONE;
    endcase
  end

endmodule

### src/nac_queue.sv
`timescale 1ns / 1ps
module nac_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  nac_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output nac_pkg::item_t item_o
);
  import nac_pkg::*;

  item_t      store_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign item_o  = store_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

### src/nac_back.sv
`timescale 1ns / 1ps
module nac_back #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  nac_pkg::item_t q_item_i,
  output logic           q_pop_o,
  output logic           init_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           ok_o,
  output logic [2:0]     addr_class_o
);
  import nac_pkg::*;

  localparam int IdxW = $clog2(TABLE_ENTRIES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  entry_t mem [TABLE_ENTRIES];

  state_e         state_q;
  item_t          cur_q;
  logic [IdxW-1:0] cnt_q;
  logic           issue_q;
  logic           rd_vld_q;
  logic [IdxW-1:0] rd_idx_q;
  entry_t         rd_q;
  logic           best_v_q;
  logic [3:0]     best_rank_q;
  logic [7:0]     best_p_q;
  logic [2:0]     best_cls_q;
  logic           ex_v_q;
  logic [IdxW-1:0] ex_idx_q;
  logic           free_v_q;
  logic [IdxW-1:0] free_idx_q;
  logic           out_valid_q;
  logic           ok_q;
  logic [2:0]     class_q;

  logic           we;
  logic [IdxW-1:0] waddr;
  entry_t         wdata;
  logic           done_ok;
  logic [2:0]     done_class;
  logic [127:0]   emask;
  logic [3:0]     rank;
  logic           lpm_hit;
  logic           exact_hit;
  logic           better;

  assign init_o       = (state_q == S_INIT);
  assign out_valid_o  = out_valid_q;
  assign ok_o         = ok_q;
  assign addr_class_o = class_q;
  assign q_pop_o      = (state_q == S_IDLE) && q_valid_i && !out_valid_q;

  always_comb begin
    emask = nac_mask(rd_q.info.fam, rd_q.info.plen);
    rank  = (rd_q.info.slot == 3'd0) ? 4'd8 : {1'b0, rd_q.info.slot};
    lpm_hit = rd_q.info.valid && rd_q.info.fam == cur_q.fam &&
              ((cur_q.key & emask) == {rd_q.key_high, rd_q.key_low});
    exact_hit = rd_q.info.valid && rd_q.info.fam == cur_q.fam &&
                rd_q.info.slot == cur_q.slot && rd_q.info.plen == cur_q.plen &&
                cur_q.key == {rd_q.key_high, rd_q.key_low};
    better = !best_v_q || rank < best_rank_q ||
             (rank == best_rank_q && rd_q.info.plen > best_p_q);
  end

  always_comb begin
    we         = 1'b0;
    waddr      = cnt_q;
    wdata      = '0;
    done_ok    = 1'b0;
    done_class = CLS_ERROR;
    case (state_q)
      S_INIT: begin
        we = 1'b1;
        if (int'(cnt_q) < BuiltinEntries) begin
          wdata = nac_builtin(cnt_q[3:0]);
        end
      end
      S_DONE: begin
        wdata.key_high  = cur_q.key[127:64];
        wdata.key_low   = cur_q.key[63:0];
        wdata.info.valid = 1'b1;
        wdata.info.fam  = cur_q.fam;
        wdata.info.slot = cur_q.slot;
        wdata.info.cls  = cur_q.cls;
        wdata.info.plen = cur_q.plen;
        case (cur_q.kind)
          KIND_ADD: begin
            if (ex_v_q) begin
              if (cur_q.fam != FAM_MAC) begin
                we = 1'b1; waddr = ex_idx_q; done_ok = 1'b1;
              end
            end else if (free_v_q) begin
              we = 1'b1; waddr = free_idx_q; done_ok = 1'b1;
            end
          end
          KIND_REMOVE: begin
            if (ex_v_q) begin
              we = 1'b1; waddr = ex_idx_q; wdata = '0; done_ok = 1'b1;
            end
          end
          KIND_CLASSIFY: begin
            done_ok = 1'b1;
            if (!best_v_q) begin
              done_class = CLS_OTHER;
            end else if (best_cls_q == CLS_LOCALNET && cur_q.host) begin
              done_class = CLS_LOCAL;
            end else begin
              done_class = best_cls_q;
            end
          end
          default: begin
            done_ok    = cur_q.res_ok;
            done_class = cur_q.res_class;
          end
        endcase
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (issue_q) begin
      rd_q <= mem[cnt_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      issue_q     <= 1'b0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      best_v_q    <= 1'b0;
      best_rank_q <= '0;
      best_p_q    <= '0;
      best_cls_q  <= '0;
      ex_v_q      <= 1'b0;
      ex_idx_q    <= '0;
      free_v_q    <= 1'b0;
      free_idx_q  <= '0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      class_q     <= '0;
      cur_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      rd_vld_q <= issue_q;
      rd_idx_q <= cnt_q;
      case (state_q)
        S_INIT: begin
          if (cnt_q == LastIdx) begin
            cnt_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (q_pop_o) begin
            cur_q    <= q_item_i;
            best_v_q <= 1'b0;
            ex_v_q   <= 1'b0;
            free_v_q <= 1'b0;
            cnt_q    <= '0;
            if (q_item_i.kind == KIND_DONE) begin
              state_q <= S_DONE;
            end else begin
              issue_q <= 1'b1;
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (issue_q) begin
            if (cnt_q == LastIdx) begin
              issue_q <= 1'b0;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
          if (rd_vld_q) begin
            if (lpm_hit && better) begin
              best_v_q    <= 1'b1;
              best_rank_q <= rank;
              best_p_q    <= rd_q.info.plen;
              best_cls_q  <= rd_q.info.cls;
            end
            if (exact_hit && !ex_v_q) begin
              ex_v_q   <= 1'b1;
              ex_idx_q <= rd_idx_q;
            end
            if (!rd_q.info.valid && !free_v_q) begin
              free_v_q   <= 1'b1;
              free_idx_q <= rd_idx_q;
            end
            if (rd_idx_q == LastIdx) begin
              state_q <= S_DONE;
            end
          end
        end
        S_DONE: begin
          out_valid_q <= 1'b1;
          ok_q        <= done_ok;
          class_q     <= done_class;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_no_out_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |-> !out_valid_q)
    else $error("result presented during table initialization");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !we)
    else $error("table written during scan");

  a_pop_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> !out_valid_q)
    else $error("transaction taken while result register full");

  a_done_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> out_valid_q)
    else $error("finished transaction produced no result");

endmodule

### src/network_address_classifier.sv
`timescale 1ns / 1ps
// Network address classifier with a prefix table.
// Input channel: in_valid_i / in_stall_o with one field port per request field
// (req_type, family, addresses, prefix length, interface slot, entry type).
// Output channel: out_valid_o / out_stall_i carrying ok_o and addr_class_o.
// A transaction is taken at a clock edge with valid high and stall low.
// Every request yields exactly one result, in request order.
// The front decodes the request and applies the fixed address rules; a two-entry
// queue separates it from the back, which scans the table memory.
// Requests settled by the fixed rules skip the scan; add, remove and table
// classification walk all TABLE_ENTRIES entries one per cycle through the single
// memory read port, and the back takes the next request only once that is done.
// After reset the back loads the built-in entries and clears the rest of the
// table; in_stall_o stays high meanwhile.
// When the receiver stalls, the result register holds its value, the back stops
// taking work, and once the queue fills in_stall_o rises.
module network_address_classifier #(
  parameter int TABLE_ENTRIES = 64,
  parameter int IFACE_SLOTS   = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [1:0]  family_i,
  input  logic [63:0] addr_high_i,
  input  logic [63:0] addr_low_i,
  input  logic [7:0]  prefix_len_i,
  input  logic [2:0]  iface_slot_i,
  input  logic [2:0]  entry_type_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        ok_o,
  output logic [2:0]  addr_class_o
);
  import nac_pkg::*;

  item_t front_item;
  item_t q_item;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;
  logic  init;
  logic  push;

  assign in_stall_o = q_full || init;
  assign push       = in_valid_i && !in_stall_o;

  nac_front #(
    .IFACE_SLOTS(IFACE_SLOTS)
  ) u_front (
    .req_type_i  (req_type_i),
    .family_i    (family_i),
    .addr_high_i (addr_high_i),
    .addr_low_i  (addr_low_i),
    .prefix_len_i(prefix_len_i),
    .iface_slot_i(iface_slot_i),
    .entry_type_i(entry_type_i),
    .item_o      (front_item)
  );

  nac_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(front_item),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .item_o     (q_item)
  );

  nac_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .init_o      (init),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ok_o        (ok_o),
    .addr_class_o(addr_class_o)
  );

endmodule

### test/tb_network_address_classifier.sv
`timescale 1ns / 1ps
module tb_network_address_classifier;
  import nac_pkg::*;

  localparam int NumEntries = 64;
  localparam int NumSlots   = 7;
  localparam int StallLimit = 20000;

  typedef struct {
    logic [1:0]  req;
    logic [1:0]  fam;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [7:0]  plen;
    logic [2:0]  slot;
    logic [2:0]  cls;
  } request_t;

  typedef struct {
    logic       ok;
    logic [2:0] cls;
  } verdict_t;

  class prefix_scoreboard;
    logic [63:0] key_hi[NumEntries];
    logic [63:0] key_lo[NumEntries];
    logic        vld[NumEntries];
    logic [1:0]  efam[NumEntries];
    logic [2:0]  eslot[NumEntries];
    logic [2:0]  ecls[NumEntries];
    logic [7:0]  eplen[NumEntries];
    verdict_t    pending[$];
    int          errors;
    int          checked;

    function void store(int i, logic [63:0] h, logic [63:0] l, logic v, logic [1:0] f,
                        logic [2:0] s, logic [2:0] c, logic [7:0] p);
      key_hi[i] = h; key_lo[i] = l; vld[i] = v; efam[i] = f;
      eslot[i] = s; ecls[i] = c; eplen[i] = p;
    endfunction

    function void clear_table();
      for (int i = 0; i < NumEntries; i++) store(i, '0, '0, 1'b0, '0, '0, '0, '0);
      store(0, '0, 64'h7F000000, 1, FAM_IP4, 0, CLS_RESERVED, 8);
      store(1, '0, 64'h0A000000, 1, FAM_IP4, 0, CLS_RESERVED, 8);
      store(2, '0, 64'h64400000, 1, FAM_IP4, 0, CLS_RESERVED, 10);
      store(3, '0, 64'hAC100000, 1, FAM_IP4, 0, CLS_RESERVED, 12);
      store(4, '0, 64'hC0A80000, 1, FAM_IP4, 0, CLS_RESERVED, 16);
      store(5, 64'hFC00000000000000, '0, 1, FAM_IP6, 0, CLS_RESERVED, 7);
      store(6, 64'hFD00000000000000, '0, 1, FAM_IP6, 0, CLS_RESERVED, 8);
      store(7, 64'hFE80000000000000, '0, 1, FAM_IP6, 0, CLS_RESERVED, 10);
      store(8, '0, 64'hE0000000, 1, FAM_IP4, 0, CLS_MULTICAST, 4);
      store(9, 64'hFF00000000000000, '0, 1, FAM_IP6, 0, CLS_MULTICAST, 8);
      store(10, '0, 64'hA9FEFFFF, 1, FAM_IP4, 0, CLS_BROADCAST, 32);
      pending.delete();
      errors = 0;
      checked = 0;
    endfunction

    function logic [127:0] prefix_mask(logic [1:0] f, int p);
      logic [127:0] m;
      m = '0;
      if (p == 0) return m;
      if (f == FAM_MAC) m[47:0] = '1;
      else if (f == FAM_IP4) begin
        for (int b = 0; b < p && b < 32; b++) m[31 - b] = 1'b1;
      end else begin
        for (int b = 0; b < p && b < 128; b++) m[127 - b] = 1'b1;
      end
      return m;
    endfunction

    function int full_len(logic [1:0] f);
      return f == FAM_MAC ? 48 : (f == FAM_IP4 ? 32 : 128);
    endfunction

    function bit normalize(request_t r, output logic [127:0] k, output int p);
      logic [127:0] a;
      k = '0;
      p = 0;
      if (r.fam == FAM_MAC) begin
        k = {80'd0, r.lo[47:0]};
        p = 48;
        return 1;
      end
      if (r.fam == FAM_IP4) begin
        if (r.plen > 32) return 0;
        p = r.plen ? r.plen : 32;
        a = {96'd0, r.lo[31:0]};
      end else if (r.fam == FAM_IP6) begin
        if (r.plen > 128) return 0;
        p = r.plen ? r.plen : 128;
        a = {r.hi, r.lo};
      end else return 0;
      k = a & prefix_mask(r.fam, p);
      return 1;
    endfunction

    function int find_equal(logic [1:0] f, logic [2:0] s, int p, logic [127:0] k);
      for (int i = 0; i < NumEntries; i++)
        if (vld[i] && efam[i] == f && eslot[i] == s && eplen[i] == p &&
            {key_hi[i], key_lo[i]} == k) return i;
      return -1;
    endfunction

    function int first_free();
      for (int i = 0; i < NumEntries; i++) if (!vld[i]) return i;
      return -1;
    endfunction

    function int best_in_slot(logic [1:0] f, logic [2:0] s, logic [127:0] q);
      int best, bestp;
      best = -1;
      bestp = 0;
      for (int i = 0; i < NumEntries; i++) begin
        if (!vld[i] || efam[i] != f || eslot[i] != s) continue;
        if ((q & prefix_mask(f, eplen[i])) != {key_hi[i], key_lo[i]}) continue;
        if (best < 0 || eplen[i] > bestp) begin
          best = i;
          bestp = eplen[i];
        end
      end
      return best < 0 ? -1 : int'(ecls[best]);
    endfunction

    function logic [2:0] lookup_class(request_t r);
      logic [127:0] k, q;
      int p, c, s;
      if (!normalize(r, k, p)) return CLS_ERROR;
      if (r.fam == FAM_MAC) begin
        if (k[40]) return CLS_MULTICAST;
        if (k[47:0] == '1) return CLS_BROADCAST;
        if (k == 0) return CLS_NONE;
        c = find_equal(FAM_MAC, 0, 48, k);
        return c < 0 ? CLS_OTHER : ecls[c];
      end
      if (r.fam == FAM_IP4) begin
        q = {96'd0, r.lo[31:0]};
        if (q == 0) return CLS_NONE;
        if (q[31:0] == '1) return CLS_BROADCAST;
      end else begin
        q = {r.hi, r.lo};
        if (q == 0) return CLS_NONE;
      end
      for (s = 1; s <= NumSlots + 1; s++) begin
        c = best_in_slot(r.fam, s == NumSlots + 1 ? 3'd0 : 3'(s), q);
        if (c >= 0) begin
          if (c == CLS_LOCALNET && p == full_len(r.fam)) c = CLS_LOCAL;
          return 3'(c);
        end
      end
      return CLS_OTHER;
    endfunction

    function void note_request(request_t r);
      verdict_t v;
      logic [127:0] k;
      logic [2:0] s, c;
      int p, i;
      v.ok = 0;
      v.cls = CLS_ERROR;
      if (r.req == REQ_CLASSIFY) begin
        v.ok = 1;
        v.cls = lookup_class(r);
      end else if ((r.req == REQ_ADD || r.req == REQ_REMOVE) && normalize(r, k, p)) begin
        s = r.fam == FAM_MAC ? 3'd0 : r.slot;
        c = r.cls;
        if (s <= NumSlots) begin
          i = find_equal(r.fam, s, p, k);
          if (r.req == REQ_REMOVE) begin
            if (i >= 0) begin
              store(i, '0, '0, 0, '0, '0, '0, '0);
              v.ok = 1;
            end
          end else if (r.fam == FAM_MAC) begin
            if (i < 0) begin
              i = first_free();
              if (i >= 0) begin
                store(i, k[127:64], k[63:0], 1, FAM_MAC, 0, c, 48);
                v.ok = 1;
              end
            end
          end else begin
            if (c == CLS_LOCAL && p != full_len(r.fam)) c = CLS_LOCALNET;
            if (i < 0) i = first_free();
            if (i >= 0) begin
              store(i, k[127:64], k[63:0], 1, r.fam, s, c, p);
              v.ok = 1;
            end
          end
        end
      end
      pending.push_back(v);
    endfunction

    function void check_result(logic ok, logic [2:0] cls);
      verdict_t v;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result ok=%0d class=%0d", $time, ok, cls);
        errors++;
        return;
      end
      v = pending.pop_front();
      if (ok !== v.ok) begin
        $display("%0t: ok mismatch, expected %0d, actual %0d", $time, v.ok, ok);
        errors++;
      end
      if (cls !== v.cls) begin
        $display("%0t: class mismatch, expected %0d, actual %0d", $time, v.cls, cls);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  req_type_i;
  logic [1:0]  family_i;
  logic [63:0] addr_high_i;
  logic [63:0] addr_low_i;
  logic [7:0]  prefix_len_i;
  logic [2:0]  iface_slot_i;
  logic [2:0]  entry_type_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        ok_o;
  logic [2:0]  addr_class_o;

  prefix_scoreboard table_model;
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;
  bit timed_out;
  int sent_items;

  network_address_classifier uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .req_type_i(req_type_i), .family_i(family_i),
    .addr_high_i(addr_high_i), .addr_low_i(addr_low_i),
    .prefix_len_i(prefix_len_i), .iface_slot_i(iface_slot_i),
    .entry_type_i(entry_type_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .ok_o(ok_o), .addr_class_o(addr_class_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) table_model.check_result(ok_o, addr_class_o);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= StallLimit) begin
      $display("watchdog expired after %0d idle cycles", quiet_cycles);
      $display("tb_network_address_classifier: done, errors");
      $finish;
    end
  end

  task automatic send(request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= r.req;
    family_i     <= r.fam;
    addr_high_i  <= r.hi;
    addr_low_i   <= r.lo;
    prefix_len_i <= r.plen;
    iface_slot_i <= r.slot;
    entry_type_i <= r.cls;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    table_model.note_request(r);
    sent_items++;
  endtask

  task automatic send_fields(logic [1:0] rq, logic [1:0] f, logic [63:0] h, logic [63:0] l,
                             logic [7:0] p, logic [2:0] s, logic [2:0] c);
    request_t r;
    r.req = rq; r.fam = f; r.hi = h; r.lo = l; r.plen = p; r.slot = s; r.cls = c;
    send(r);
  endtask

  function automatic request_t random_request();
    request_t r;
    int pick;
    r.req  = $urandom_range(99) < 50 ? REQ_CLASSIFY :
             ($urandom_range(99) < 65 ? REQ_ADD : REQ_REMOVE);
    if ($urandom_range(99) < 3) r.req = 2'd3;
    pick = $urandom_range(99);
    r.fam  = pick < 20 ? FAM_MAC : (pick < 60 ? FAM_IP4 : (pick < 97 ? FAM_IP6 : 2'd3));
    r.hi   = {$urandom, $urandom};
    r.lo   = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 30) begin
      // Land inside the built-in or commonly added prefixes.
      case ($urandom_range(5))
        0: r.lo[31:24] = 8'd10;
        1: r.lo[31:16] = 16'hC0A8;
        2: r.hi[63:56] = 8'hFD;
        3: r.hi[63:54] = 10'b1111111010;
        4: r.lo[31:28] = 4'hE;
        default: r.lo[31:24] = 8'd127;
      endcase
      r.lo[23:8] = 16'($urandom_range(3));
    end else if (pick < 35) begin
      r.hi = '0;
      r.lo = $urandom_range(1) ? '0 : '1;
    end
    pick = $urandom_range(99);
    if (pick < 15) r.plen = 0;
    else if (pick < 92) r.plen = r.fam == FAM_IP4 ? 8'($urandom_range(32)) :
                                                    8'($urandom_range(128));
    else r.plen = 8'($urandom_range(255));
    r.slot = $urandom_range(99) < 40 ? 3'd0 : 3'($urandom_range(7));
    r.cls  = 3'($urandom_range(1, 7));
    if ($urandom_range(99) < 2) r.cls = 0;
    return r;
  endfunction

  task automatic drain();
    while (table_model.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  initial begin
    table_model = new();
    table_model.clear_table();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    req_type_i = '0; family_i = '0; addr_high_i = '0; addr_low_i = '0;
    prefix_len_i = '0; iface_slot_i = '0; entry_type_i = '0;
    quiet_cycles = 0;
    sent_items = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_fields(REQ_CLASSIFY, FAM_IP4, '0, 64'h0A010203, 0, 0, 0);
    send_fields(REQ_CLASSIFY, FAM_IP4, '0, 64'h0, 0, 0, 0);
    send_fields(REQ_CLASSIFY, FAM_IP4, '0, 64'hFFFFFFFF, 0, 0, 0);
    send_fields(REQ_CLASSIFY, FAM_IP4, '0, 64'hA9FEFFFF, 0, 0, 0);
    send_fields(REQ_CLASSIFY, FAM_IP4, '0, 64'h08080808, 33, 0, 0);
    send_fields(REQ_CLASSIFY, FAM_IP6, '0, '0, 0, 0, 0);
    send_fields(REQ_CLASSIFY, FAM_IP6, 64'hFE80000000000001, 64'h1, 0, 0, 0);
    send_fields(REQ_CLASSIFY, FAM_IP6, '1, '1, 255, 0, 0);
    send_fields(REQ_CLASSIFY, FAM_MAC, '0, 64'h010000000000, 0, 0, 0);
    send_fields(REQ_CLASSIFY, FAM_MAC, '0, 64'hFFFFFFFFFFFF, 0, 0, 0);
    send_fields(REQ_CLASSIFY, FAM_MAC, '1, 64'hFFFF000000000000, 0, 0, 0);
    send_fields(REQ_ADD, FAM_MAC, '0, 64'h020000000001, 0, 5, CLS_LOCAL);
    send_fields(REQ_ADD, FAM_MAC, '0, 64'h020000000001, 0, 0, CLS_LOCAL);
    send_fields(REQ_CLASSIFY, FAM_MAC, '0, 64'h020000000001, 0, 0, 0);
    send_fields(REQ_ADD, FAM_IP4, '0, 64'h08080808, 24, 3, CLS_LOCAL);
    send_fields(REQ_CLASSIFY, FAM_IP4, '0, 64'h08080801, 0, 0, 0);
    send_fields(REQ_CLASSIFY, FAM_IP4, '0, 64'h08080801, 24, 0, 0);
    send_fields(REQ_ADD, FAM_IP4, '0, 64'h08080800, 24, 3, CLS_OTHER);
    send_fields(REQ_ADD, FAM_IP6, '1, '1, 129, 0, CLS_LOCAL);
    send_fields(REQ_ADD, 2'd3, '0, 64'h1, 8, 0, CLS_LOCAL);
    send_fields(REQ_REMOVE, FAM_IP4, '0, 64'h0A000000, 8, 0, 0);
    send_fields(REQ_REMOVE, FAM_IP4, '0, 64'h0A000000, 8, 0, 0);
    send_fields(2'd3, FAM_IP4, '0, 64'h1, 0, 0, 0);
    send_fields(REQ_ADD, FAM_IP6, '0, '0, 128, 7, CLS_BROADCAST);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = ph == 0 ? 24 : (ph == 1 ? 76 : 0);
      recv_idle_pct = ph == 0 ? 76 : (ph == 1 ? 24 : 0);
      for (int n = 0; n < 510; n++) send(random_request());
    end
    in_valid_i <= 1'b0;
    drain();
    $display("Sent %0d requests (adds, removes, classifies of all families), %0d results checked.",
             sent_items, table_model.checked);
    if (table_model.errors == 0 && table_model.pending.size() == 0)
      $display("tb_network_address_classifier: done, clean");
    else
      $display("tb_network_address_classifier: done, errors");
    $finish;
  end
endmodule

### sim.f
src/nac_pkg.sv
src/nac_front.sv
src/nac_queue.sv
src/nac_back.sv
src/network_address_classifier.sv
test/tb_network_address_classifier.sv
